/* rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned FUNC_W          = 3;
    localparam int unsigned DEPTH_OUT_W     = 5;
    localparam int unsigned STATUS_W        = 2;

    // token codes on the input word
    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_END  = 3'd5;

    // status codes on the result word
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_END,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV
    } t_back_state;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] last_result;
        logic [DEPTH_OUT_W-1:0]   depth_now;
        logic [STATUS_W-1:0]      status;
        logic                     expression_done;
    } t_out_item;

    // decoded token handed from front to back
    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_q_item;

endpackage

/* rtl/rpn_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Postfix integer evaluator on a bounded operand stack.
// ----------------------------------------------------------------------------
// Tokens come in through a queue-style port: a word is taken on a clock edge
// with push high and full low. A two-entry intake queue decodes tokens and
// keeps taking them while the execution side is busy or its result waits.
// Each token gives one result word. It sits on o_result while empty is low
// and leaves on an edge with pop high; until then the execution side holds
// off the next token, and once the intake queue fills, full rises.
// Push, end and unused codes and any error have their result word
// registered as the token is decoded; add and subtract first read the
// stack, multiply also registers the product, and divide reads the stack
// and then runs the radix-2 divider, which takes one quotient bit per cycle.
// Tokens are carried out one at a time and the next starts only after the
// result word is popped.
// Synchronous active-low reset empties the stack, clears the last result
// and both queues; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rpn_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output rpn_pkg::t_out_item o_result
);
    import rpn_pkg::*;

    logic    w_q_valid;
    t_q_item w_q_item;
    logic    w_q_pop;

    rpn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

/* rtl/rpn_front.sv */
// ----------------------------------------------------------------------------
// rpn_front
// Token intake: decodes each word and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module rpn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rpn_pkg::t_in_item i_item,
    output logic              o_q_valid,
    output rpn_pkg::t_q_item  o_q_item,
    input  logic              i_q_pop
);
    import rpn_pkg::*;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned PTR_W  = $clog2(QDEPTH);
    localparam int unsigned FILL_W = $clog2(QDEPTH + 1);

    t_q_item           r_slot [QDEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [FILL_W-1:0] r_fill;
    logic              w_wr;
    t_q_item           w_dec;

    always_comb begin
        w_dec.value = i_item.operand_value;
        unique case (i_item.func)
            FN_PUSH: w_dec.op = OP_PUSH;
            FN_ADD:  w_dec.op = OP_ADD;
            FN_SUB:  w_dec.op = OP_SUB;
            FN_MUL:  w_dec.op = OP_MUL;
            FN_DIV:  w_dec.op = OP_DIV;
            FN_END:  w_dec.op = OP_END;
            default: w_dec.op = OP_NOP;
        endcase
    end

    assign full      = (r_fill == FILL_W'(QDEPTH));
    assign w_wr      = push && !full;
    assign o_q_valid = (r_fill != '0);
    assign o_q_item  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wptr] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_wr, i_q_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* rtl/rpn_div.sv */
// ----------------------------------------------------------------------------
// rpn_div
// Signed 32-bit divider, radix-2 restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rpn_pkg::DATA_W-1:0] i_dividend,
    input  logic [rpn_pkg::DATA_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rpn_pkg::DATA_W-1:0] o_quot
);
    import rpn_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_abs_y;
    logic [DATA_W-1:0] w_abs_x;

    assign w_abs_y  = i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
    assign w_abs_x  = i_divisor[DATA_W-1]  ? (DATA_W'(0) - i_divisor)  : i_divisor;
    assign w_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    // quotient sign is applied after the last step
    assign o_done = r_done;
    assign o_quot = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_abs_y;
            r_den <= w_abs_x;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_diff[DATA_W] ? w_rem_sh[DATA_W-1:0] : w_diff[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], ~w_diff[DATA_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/rpn_back.sv */
// ----------------------------------------------------------------------------
// rpn_back
// Execution side: operand stack, arithmetic sequencer and result register.
// ----------------------------------------------------------------------------
module rpn_back #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  rpn_pkg::t_q_item   i_q_item,
    output logic               o_q_pop,
    output logic               empty,
    input  logic               pop,
    output rpn_pkg::t_out_item o_result
);
    import rpn_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    // top of stack lives in r_tos, entries below it in r_stack
    logic [DATA_W-1:0] r_stack [STACK_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    t_back_state       r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_tos, n_tos;
    logic [DATA_W-1:0] r_hold, n_hold;
    t_op               r_op, n_op;
    logic [DATA_W-1:0] r_prod, n_prod;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              w_mem_we;
    logic              w_rd_en;
    logic [CW-1:0]     w_cm1;
    logic [CW-1:0]     w_cm2;
    logic              w_emit;
    logic [STATUS_W-1:0] w_status;
    logic              w_done;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_div_quot;
    logic [CW+DEPTH_OUT_W-1:0] w_depth_ext;

    assign w_cm1       = r_count - CW'(1);
    assign w_cm2       = r_count - CW'(2);
    assign w_depth_ext = {{DEPTH_OUT_W{1'b0}}, n_count};

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rdata),
        .i_divisor  (r_tos),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_tos       = r_tos;
        n_hold      = r_hold;
        n_op        = r_op;
        n_prod      = r_prod;
        o_q_pop     = 1'b0;
        w_mem_we    = 1'b0;
        w_rd_en     = 1'b0;
        w_emit      = 1'b0;
        w_status    = ST_OK;
        w_done      = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // next token only once the previous result has left
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.op) inside
                        OP_PUSH: begin
                            w_emit = 1'b1;
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                w_status = ST_OVER;
                            end else begin
                                w_mem_we = (r_count != '0);
                                n_tos    = i_q_item.value;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (r_count < CW'(2)) begin
                                w_emit   = 1'b1;
                                w_status = ST_UNDER;
                            end else if (i_q_item.op == OP_DIV && r_tos == '0) begin
                                w_emit   = 1'b1;
                                w_status = ST_DIV0;
                            end else begin
                                w_rd_en = 1'b1;
                                n_op    = i_q_item.op;
                                n_state = S_READ;
                            end
                        end
                        OP_END: begin
                            w_emit  = 1'b1;
                            w_done  = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                unique case (r_op)
                    OP_ADD: begin
                        n_tos   = r_rdata + r_tos;
                        n_hold  = n_tos;
                        n_count = w_cm1;
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_SUB: begin
                        n_tos   = r_rdata - r_tos;
                        n_hold  = n_tos;
                        n_count = w_cm1;
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_MUL: begin
                        n_prod  = r_rdata * r_tos;
                        n_state = S_MUL;
                    end
                    default: begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                endcase
            end
            S_MUL: begin
                n_tos   = r_prod;
                n_hold  = r_prod;
                n_count = w_cm1;
                w_emit  = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_tos   = w_div_quot;
                    n_hold  = w_div_quot;
                    n_count = w_cm1;
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_stack[w_cm1[AW-1:0]] <= r_tos;
        end
        if (w_rd_en) begin
            r_rdata <= r_stack[w_cm2[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos  <= n_tos;
        r_op   <= n_op;
        r_prod <= n_prod;
        if (w_emit) begin
            r_out.last_result     <= n_hold;
            r_out.depth_now       <= w_depth_ext[DEPTH_OUT_W-1:0];
            r_out.status          <= w_status;
            r_out.expression_done <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hold  <= n_hold;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

/* rtl/rpn_checker.sv */
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks for the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input rpn_pkg::t_out_item o_result
);
    import rpn_pkg::*;

    // both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a waiting result word holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result word changed while waiting");

    // end of expression always leaves an empty stack and ok status
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.expression_done |->
            o_result.depth_now == '0 && o_result.status == ST_OK)
        else $error("end of expression did not clear stack");

    // underflow can only be reported with fewer than two entries
    a_under_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status == ST_UNDER |->
            o_result.depth_now < DEPTH_OUT_W'(2) && !o_result.expression_done)
        else $error("underflow reported with operands present");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the postfix stack evaluator. A table of directed
// tokens covers the corners, then mostly well-formed random expressions mixed
// with noise tokens run under three sender/receiver idle profiles. Each result
// word is checked per field against a typed table row or an in-bench stack model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int unsigned DEPTH       = STACK_DEPTH_DEF;
    localparam int          PHASE_WORDS = 260;
    localparam int          LONG_STALL  = 300;
    localparam int          END_WAIT    = 60;
    localparam int          LIMIT       = 400000;
    localparam int          MAX_REPORTS = 30;
    localparam int          DIR_ROWS    = 24;

    // codes the block decodes as no-ops
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

    typedef struct packed {
        t_in_item  tok;
        logic [4:0] reps;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    localparam t_out_item NONE = '0;

    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{'{FN_ADD,    32'h0000_0000}, 5'd1, 1'b1, '{32'h0000_0000, 5'd0, ST_UNDER, 1'b0}},
        '{'{FN_SPARE6, 32'hFFFF_FFFF}, 5'd1, 1'b1, '{32'h0000_0000, 5'd0, ST_OK,    1'b0}},
        '{'{FN_SPARE7, 32'h1234_5678}, 5'd1, 1'b1, '{32'h0000_0000, 5'd0, ST_OK,    1'b0}},
        '{'{FN_END,    32'hDEAD_BEEF}, 5'd1, 1'b1, '{32'h0000_0000, 5'd0, ST_OK,    1'b1}},
        '{'{FN_PUSH,   32'h7FFF_FFFF}, 5'd1, 1'b1, '{32'h0000_0000, 5'd1, ST_OK,    1'b0}},
        '{'{FN_SUB,    32'h0000_0000}, 5'd1, 1'b1, '{32'h0000_0000, 5'd1, ST_UNDER, 1'b0}},
        '{'{FN_PUSH,   32'h0000_0001}, 5'd1, 1'b1, '{32'h0000_0000, 5'd2, ST_OK,    1'b0}},
        '{'{FN_ADD,    32'hFFFF_FFFF}, 5'd1, 1'b1, '{32'h8000_0000, 5'd1, ST_OK,    1'b0}},
        '{'{FN_PUSH,   32'hFFFF_FFFF}, 5'd1, 1'b1, '{32'h8000_0000, 5'd2, ST_OK,    1'b0}},
        '{'{FN_DIV,    32'h0000_0000}, 5'd1, 1'b1, '{32'h8000_0000, 5'd1, ST_OK,    1'b0}},
        '{'{FN_PUSH,   32'h0000_0000}, 5'd1, 1'b1, '{32'h8000_0000, 5'd2, ST_OK,    1'b0}},
        '{'{FN_DIV,    32'h5555_5555}, 5'd1, 1'b1, '{32'h8000_0000, 5'd2, ST_DIV0,  1'b0}},
        '{'{FN_MUL,    32'h0000_0000}, 5'd1, 1'b1, '{32'h0000_0000, 5'd1, ST_OK,    1'b0}},
        '{'{FN_PUSH,   32'h8000_0000}, 5'd1, 1'b0, NONE},
        '{'{FN_MUL,    32'h0000_0000}, 5'd1, 1'b0, NONE},
        '{'{FN_PUSH,   32'hFFFF_FFF9}, 5'd1, 1'b0, NONE},
        '{'{FN_PUSH,   32'h0000_0002}, 5'd1, 1'b0, NONE},
        '{'{FN_DIV,    32'h0000_0000}, 5'd1, 1'b0, NONE},
        '{'{FN_SUB,    32'h0000_0000}, 5'd1, 1'b0, NONE},
        '{'{FN_PUSH,   32'h0000_0007}, 5'd15, 1'b0, NONE},
        '{'{FN_PUSH,   32'hA5A5_A5A5}, 5'd1, 1'b1, '{32'h0000_0003, 5'd16, ST_OVER, 1'b0}},
        '{'{FN_DIV,    32'h0000_0000}, 5'd1, 1'b0, NONE},
        '{'{FN_END,    32'h0000_0000}, 5'd1, 1'b1, '{32'h0000_0001, 5'd0, ST_OK,    1'b1}},
        '{'{FN_MUL,    32'h0000_0000}, 5'd1, 1'b1, '{32'h0000_0001, 5'd0, ST_UNDER, 1'b0}}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    // stack model state
    logic [DATA_W-1:0] stk_words [DEPTH];
    int unsigned       stk_fill = 0;
    logic [DATA_W-1:0] held_result = '0;

    t_out_item pending_results [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic rx_hold = 1'b0;
    bit  holdoff_go = 1'b0;
    int  tokens_sent = 0;
    int  words_checked = 0;
    int  fail_count = 0;
    int  n_under = 0;
    int  n_over = 0;
    int  n_div0 = 0;
    int  n_done = 0;
    int  cycle_count = 0;

    rpn_stack_evaluator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quo;
        mag_n = num[DATA_W-1] ? (32'd0 - num) : num;
        mag_d = den[DATA_W-1] ? (32'd0 - den) : den;
        quo = mag_n / mag_d;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? (32'd0 - quo) : quo;
    endfunction

    // advances the stack model by one token and returns the word it yields
    function automatic t_out_item eval_token(input t_in_item w);
        t_out_item         res;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] nxt;
        logic [DATA_W-1:0] val;
        res = '0;
        res.status = ST_OK;
        case (w.func) inside
            FN_PUSH: begin
                if (stk_fill >= DEPTH) begin
                    res.status = ST_OVER;
                end else begin
                    stk_words[stk_fill] = w.operand_value;
                    stk_fill++;
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                if (stk_fill < 2) begin
                    res.status = ST_UNDER;
                end else begin
                    top = stk_words[stk_fill-1];
                    nxt = stk_words[stk_fill-2];
                    if (w.func == FN_DIV && top == '0) begin
                        res.status = ST_DIV0;
                    end else begin
                        case (w.func)
                            FN_ADD: val = nxt + top;
                            FN_SUB: val = nxt - top;
                            FN_MUL: val = nxt * top;
                            default: val = trunc_quotient(nxt, top);
                        endcase
                        stk_fill--;
                        stk_words[stk_fill-1] = val;
                        held_result = val;
                    end
                end
            end
            FN_END: begin
                stk_fill = 0;
                res.expression_done = 1'b1;
            end
            default: ;
        endcase
        res.last_result = held_result;
        res.depth_now = DEPTH_OUT_W'(stk_fill);
        return res;
    endfunction

    task automatic offer_token(input t_in_item w, input logic typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = eval_token(w);
        pending_results.push_back(typed ? want : predicted);
        tokens_sent++;
    endtask

    function automatic logic [DATA_W-1:0] rand_operand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return $urandom;
        if (pick < 70) return 32'($signed($urandom_range(40)) - 20);
        if (pick < 80) return '0;
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic offer_random(input logic [FUNC_W-1:0] fn);
        t_in_item w;
        w.func = fn;
        w.operand_value = rand_operand();
        offer_token(w, 1'b0, NONE);
    endtask

    function automatic logic [FUNC_W-1:0] rand_operator();
        return FN_ADD + FUNC_W'($urandom_range(3));
    endfunction

    // mostly complete expressions with random content, some cut short or noise
    task automatic random_phase(input int n_words);
        int   target;
        int   n_nums;
        int   d;
        int   k;
        logic deep;
        target = tokens_sent + n_words;
        while (tokens_sent < target) begin
            if ($urandom_range(99) < 12) begin
                offer_random(FUNC_W'($urandom_range(7)));
            end else begin
                deep = ($urandom_range(99) < 6);
                n_nums = deep ? DEPTH + 2 : $urandom_range(1, 7);
                d = 0;
                for (k = 0; k < n_nums; k++) begin
                    offer_random(FN_PUSH);
                    if (d < DEPTH) d++;
                    while (!deep && d >= 2 && $urandom_range(2) == 0) begin
                        offer_random(rand_operator());
                        d--;
                    end
                end
                if ($urandom_range(9) != 0) begin
                    while (d >= 2) begin
                        offer_random(rand_operator());
                        d--;
                    end
                end
                offer_random(FN_END);
            end
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string fname, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        if (fail_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
        fail_count++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: unexpected word, expected none actual %h", $time, got);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.last_result !== want.last_result)
                report_field("last_result", want.last_result, got.last_result);
            if (got.depth_now !== want.depth_now)
                report_field("depth_now", DATA_W'(want.depth_now), DATA_W'(got.depth_now));
            if (got.status !== want.status)
                report_field("status", DATA_W'(want.status), DATA_W'(got.status));
            if (got.expression_done !== want.expression_done)
                report_field("expression_done", DATA_W'(want.expression_done),
                             DATA_W'(got.expression_done));
            words_checked++;
            case (want.status)
                ST_UNDER: n_under++;
                ST_OVER:  n_over++;
                ST_DIV0:  n_div0++;
                default:  ;
            endcase
            if (want.expression_done) n_done++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_result(o_result);
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall so the intake queue fills and full rises
    initial begin : rx_holdoff
        wait (holdoff_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_STALL) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 87;
        for (r = 0; r < DIR_ROWS; r++) begin
            for (n = 0; n < DIR_TAB[r].reps; n++)
                offer_token(DIR_TAB[r].tok, DIR_TAB[r].typed, DIR_TAB[r].want);
        end
        random_phase(PHASE_WORDS);
        drain_results();

        send_idle_pct = 87;
        recv_idle_pct = 12;
        random_phase(PHASE_WORDS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_go = 1'b1;
        random_phase(PHASE_WORDS);
        drain_results();

        repeat (END_WAIT) @(posedge i_clk);
        $display("covered %0d tokens, %0d result words checked", tokens_sent, words_checked);
        $display("underflow %0d, overflow %0d, divide by zero %0d, expressions ended %0d",
                 n_under, n_over, n_div0, n_done);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* rpn_stack_evaluator.f */
rtl/rpn_pkg.sv
rtl/rpn_front.sv
rtl/rpn_div.sv
rtl/rpn_back.sv
rtl/rpn_stack_evaluator.sv
rtl/rpn_checker.sv
tb/tb.sv
